>>> sv/acct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acct_pkg
// Shared widths and item types for the box / circle collision pipeline.
// ----------------------------------------------------------------------------
package acct_pkg;

	localparam int COORD_BITS = 16;
	localparam int SIZE_BITS  = COORD_BITS - 1;
	localparam int DBL_BITS   = COORD_BITS + 2;   // doubled coordinates
	localparam int RAD_BITS   = COORD_BITS;       // radius or sum of radii
	localparam int SQ_BITS    = 2 * DBL_BITS;
	localparam int RSQ_BITS   = 2 * RAD_BITS;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic        [SIZE_BITS-1:0]  size_t;
	typedef logic signed [DBL_BITS-1:0]   dbl_t;
	typedef logic        [DBL_BITS-1:0]   mag_t;
	typedef logic        [RAD_BITS-1:0]   rad_t;

	typedef struct packed {
		logic   first_is_circle;
		coord_t first_x;
		coord_t first_y;
		size_t  first_w;
		size_t  first_h;
		logic   second_is_circle;
		coord_t second_x;
		coord_t second_y;
		size_t  second_w;
		size_t  second_h;
	} pair_t;

	typedef struct packed {
		logic hit;
		logic bounds_overlap;
	} result_t;

	typedef struct packed {
		logic coarse;
		logic box_only;
		dbl_t cx;
		dbl_t cy;
		dbl_t lox;
		dbl_t hix;
		dbl_t loy;
		dbl_t hiy;
		rad_t rad;
	} s1_t;

	typedef struct packed {
		logic coarse;
		logic box_only;
		mag_t mx;
		mag_t my;
		rad_t rad;
	} s2_t;

	typedef struct packed {
		logic                coarse;
		logic                box_only;
		logic [SQ_BITS-1:0]  sqx;
		logic [SQ_BITS-1:0]  sqy;
		logic [RSQ_BITS-1:0] rsq;
	} s3_t;

endpackage

>>> sv/acct_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acct_setup
// Stage 1: doubled bounds, coarse box overlap, circle / box role selection.
// ----------------------------------------------------------------------------
module acct_setup (
	input  logic           clk,
	input  logic           en,
	input  acct_pkg::pair_t pair,
	output acct_pkg::s1_t   s1
);
	import acct_pkg::*;

	dbl_t a_lox, a_hix, a_loy, a_hiy, a_cx, a_cy;
	dbl_t b_lox, b_hix, b_loy, b_hiy, b_cx, b_cy;
	s1_t  nxt;

	always_comb begin
		a_lox = {pair.first_x[COORD_BITS-1], pair.first_x, 1'b0};
		a_loy = {pair.first_y[COORD_BITS-1], pair.first_y, 1'b0};
		a_hix = a_lox + {2'b00, pair.first_w, 1'b0};
		a_hiy = a_loy + {2'b00, pair.first_h, 1'b0};
		a_cx  = a_lox + {3'b000, pair.first_w};
		a_cy  = a_loy + {3'b000, pair.first_h};
		b_lox = {pair.second_x[COORD_BITS-1], pair.second_x, 1'b0};
		b_loy = {pair.second_y[COORD_BITS-1], pair.second_y, 1'b0};
		b_hix = b_lox + {2'b00, pair.second_w, 1'b0};
		b_hiy = b_loy + {2'b00, pair.second_h, 1'b0};
		b_cx  = b_lox + {3'b000, pair.second_w};
		b_cy  = b_loy + {3'b000, pair.second_h};

		nxt.coarse   = (a_hix > b_lox) && (a_lox < b_hix) &&
		               (a_hiy > b_loy) && (a_loy < b_hiy);
		nxt.box_only = !pair.first_is_circle && !pair.second_is_circle;

		// two circles: clamp window collapses onto the second center
		priority if (pair.first_is_circle && pair.second_is_circle) begin
			nxt.cx  = a_cx;
			nxt.cy  = a_cy;
			nxt.lox = b_cx;
			nxt.hix = b_cx;
			nxt.loy = b_cy;
			nxt.hiy = b_cy;
			nxt.rad = {1'b0, pair.first_w} + {1'b0, pair.second_w};
		end else if (pair.second_is_circle) begin
			nxt.cx  = b_cx;
			nxt.cy  = b_cy;
			nxt.lox = a_lox;
			nxt.hix = a_hix;
			nxt.loy = a_loy;
			nxt.hiy = a_hiy;
			nxt.rad = {1'b0, pair.second_w};
		end else begin
			nxt.cx  = a_cx;
			nxt.cy  = a_cy;
			nxt.lox = b_lox;
			nxt.hix = b_hix;
			nxt.loy = b_loy;
			nxt.hiy = b_hiy;
			nxt.rad = {1'b0, pair.first_w};
		end
	end

	s1_t s1_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			s1_s1 <= nxt;
		end
	end

	assign s1 = s1_s1;

endmodule

>>> sv/acct_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acct_clamp
// Stage 2: distance from the circle center to the clamped nearest point.
// ----------------------------------------------------------------------------
module acct_clamp (
	input  logic          clk,
	input  logic          en,
	input  acct_pkg::s1_t s1,
	output acct_pkg::s2_t s2
);
	import acct_pkg::*;

	logic [DBL_BITS:0] dlox, dhix, dloy, dhiy;
	s2_t nxt;

	always_comb begin
		dlox = {s1.lox[DBL_BITS-1], s1.lox} - {s1.cx[DBL_BITS-1], s1.cx};
		dhix = {s1.cx[DBL_BITS-1], s1.cx} - {s1.hix[DBL_BITS-1], s1.hix};
		dloy = {s1.loy[DBL_BITS-1], s1.loy} - {s1.cy[DBL_BITS-1], s1.cy};
		dhiy = {s1.cy[DBL_BITS-1], s1.cy} - {s1.hiy[DBL_BITS-1], s1.hiy};

		nxt.coarse   = s1.coarse;
		nxt.box_only = s1.box_only;
		nxt.rad      = s1.rad;

		priority if (s1.cx < s1.lox) begin
			nxt.mx = dlox[DBL_BITS-1:0];
		end else if (s1.cx > s1.hix) begin
			nxt.mx = dhix[DBL_BITS-1:0];
		end else begin
			nxt.mx = '0;
		end

		priority if (s1.cy < s1.loy) begin
			nxt.my = dloy[DBL_BITS-1:0];
		end else if (s1.cy > s1.hiy) begin
			nxt.my = dhiy[DBL_BITS-1:0];
		end else begin
			nxt.my = '0;
		end
	end

	s2_t s2_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			s2_s2 <= nxt;
		end
	end

	assign s2 = s2_s2;

endmodule

>>> sv/acct_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acct_square
// Stage 3: squares of both offsets and of the radius.
// ----------------------------------------------------------------------------
module acct_square (
	input  logic          clk,
	input  logic          en,
	input  acct_pkg::s2_t s2,
	output acct_pkg::s3_t s3
);
	import acct_pkg::*;

	logic [SQ_BITS-1:0]  px, py;
	logic [RSQ_BITS-1:0] pr;

	assign px = s2.mx * s2.mx;
	assign py = s2.my * s2.my;
	assign pr = s2.rad * s2.rad;

	s3_t s3_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			s3_s3.coarse   <= s2.coarse;
			s3_s3.box_only <= s2.box_only;
			s3_s3.sqx      <= px;
			s3_s3.sqy      <= py;
			s3_s3.rsq      <= pr;
		end
	end

	assign s3 = s3_s3;

endmodule

>>> sv/aabb_circle_collision_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_circle_collision_test
// Strict 2D collision test for a pair of box or circle colliders, pipelined.
//
//   channel   handshake                   payload
//   pair      pair_valid / pair_stall     acct_pkg::pair_t
//   result    result_valid / result_stall acct_pkg::result_t
//
// One item per cycle while pair_stall is low; valid_q drives result_valid.
// Stages: bounds and overlap, clamp, squares, sum/compare into the output reg.
// A stall on result freezes only the stages that are full; bubbles still move.
// arst_n clears the valid bits; no payload register is reset.
// ----------------------------------------------------------------------------
module aabb_circle_collision_test (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pair_valid,
	output logic              pair_stall,
	input  acct_pkg::pair_t   pair,
	output logic              result_valid,
	input  logic              result_stall,
	output acct_pkg::result_t result
);
	import acct_pkg::*;

	logic v_s1, v_s2, v_s3, valid_q;
	logic en1, en2, en3, en4;
	s1_t  s1;
	s2_t  s2;
	s3_t  s3;

	assign en4        = !valid_q || !result_stall;
	assign en3        = !v_s3 || en4;
	assign en2        = !v_s2 || en3;
	assign en1        = !v_s1 || en2;
	assign pair_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= pair_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) valid_q <= v_s3;
		end
	end

	acct_setup u_setup (
		.clk  (clk),
		.en   (en1),
		.pair (pair),
		.s1   (s1)
	);

	acct_clamp u_clamp (
		.clk (clk),
		.en  (en2),
		.s1  (s1),
		.s2  (s2)
	);

	acct_square u_square (
		.clk (clk),
		.en  (en3),
		.s2  (s2),
		.s3  (s3)
	);

	logic [SQ_BITS:0] dist_sum;
	logic             in_circle;
	result_t          result_q;

	assign dist_sum  = {1'b0, s3.sqx} + {1'b0, s3.sqy};
	assign in_circle = dist_sum < {{(SQ_BITS + 1 - RSQ_BITS){1'b0}}, s3.rsq};

	always_ff @(posedge clk) begin
		if (en4) begin
			result_q.hit            <= s3.coarse && (s3.box_only || in_circle);
			result_q.bounds_overlap <= s3.coarse;
		end
	end

	assign result_valid = valid_q;
	assign result       = result_q;

	a_hit_needs_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (!result.hit || result.bounds_overlap))
		else $error("hit without bounds overlap");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		pair_stall |-> (v_s1 && v_s2 && v_s3 && valid_q))
		else $error("input stalled with a free stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_valid && !pair_stall) |=> v_s1)
		else $error("accepted item not in stage 1");

	a_stage3_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && valid_q && result_stall) |=> (v_s3 && valid_q))
		else $error("item lost under output stall");

endmodule
